// File: hw/rtl/acctilt_pkg.sv
package acctilt_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int LANES      = 2;
  localparam int GUARD_BITS = 24;
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_W     = 23;
  localparam int ANG_FRAC   = 16;

  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = ROOT_W + 2;
  localparam int NUM_W  = 32;
  localparam int XY_W   = ROOT_W + GUARD_BITS + 4;
  localparam int Z_W    = 25;
  localparam int DEG_W  = 8;
  localparam int DEG_MAX = 90;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] ymag;
  } lane_meta_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [ATAN_W-1:0] atan_entry(input int idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      0:       v = 23'd2949120;
      1:       v = 23'd1740967;
      2:       v = 23'd919879;
      3:       v = 23'd466945;
      4:       v = 23'd234379;
      5:       v = 23'd117304;
      6:       v = 23'd58666;
      7:       v = 23'd29335;
      8:       v = 23'd14668;
      9:       v = 23'd7334;
      10:      v = 23'd3667;
      11:      v = 23'd1833;
      12:      v = 23'd917;
      13:      v = 23'd458;
      14:      v = 23'd229;
      15:      v = 23'd115;
      16:      v = 23'd57;
      17:      v = 23'd29;
      18:      v = 23'd14;
      19:      v = 23'd7;
      20:      v = 23'd4;
      21:      v = 23'd2;
      22:      v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/acctilt_sqrt.sv
module acctilt_sqrt (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [acctilt_pkg::RAD_W-1:0]          in_rad  [acctilt_pkg::LANES],
  input  acctilt_pkg::lane_meta_t                in_meta [acctilt_pkg::LANES],
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [acctilt_pkg::ROOT_W-1:0]         out_root [acctilt_pkg::LANES],
  output acctilt_pkg::lane_meta_t                out_meta [acctilt_pkg::LANES]
);

  localparam int N      = acctilt_pkg::ROOT_W;
  localparam int LANES  = acctilt_pkg::LANES;
  localparam int RAD_W  = acctilt_pkg::RAD_W;
  localparam int ROOT_W = acctilt_pkg::ROOT_W;
  localparam int REM_W  = acctilt_pkg::REM_W;

  logic                    v_r      [0:N];
  logic                    rdy      [0:N];
  logic [RAD_W-1:0]        rad_r    [LANES][0:N];
  logic [REM_W-1:0]        rem_r    [LANES][0:N];
  logic [ROOT_W-1:0]       root_r   [LANES][0:N];
  acctilt_pkg::lane_meta_t meta_r   [LANES][0:N];
  logic [REM_W-1:0]        rem_nxt  [LANES][1:N];
  logic [ROOT_W-1:0]       root_nxt [LANES][1:N];

  // bubbles collapse: a stage loads when it is empty or the next one moves
  assign rdy[N] = !v_r[N] || out_ready;
  for (genvar k = 0; k < N; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[N];

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_root[l] = root_r[l][N];
    assign out_meta[l] = meta_r[l][N];
  end

  // one root bit per stage, restoring
  always_comb begin
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    for (int l = 0; l < LANES; l++) begin
      for (int k = 1; k <= N; k++) begin
        cur   = {rem_r[l][k-1][REM_W-3:0], rad_r[l][k-1][RAD_W-1 -: 2]};
        trial = {root_r[l][k-1], 2'b01};
        if (cur >= trial) begin
          rem_nxt[l][k]  = cur - trial;
          root_nxt[l][k] = {root_r[l][k-1][ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt[l][k]  = cur;
          root_nxt[l][k] = {root_r[l][k-1][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k <= N; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (rdy[0] && in_valid) begin
        rad_r[l][0]  <= in_rad[l];
        rem_r[l][0]  <= '0;
        root_r[l][0] <= '0;
        meta_r[l][0] <= in_meta[l];
      end
      for (int k = 1; k <= N; k++) begin
        if (rdy[k] && v_r[k-1]) begin
          rad_r[l][k]  <= rad_r[l][k-1] << 2;
          rem_r[l][k]  <= rem_nxt[l][k];
          root_r[l][k] <= root_nxt[l][k];
          meta_r[l][k] <= meta_r[l][k-1];
        end
      end
    end
  end

endmodule

// File: hw/rtl/acctilt_cordic.sv
module acctilt_cordic #(
  parameter int CORDIC_STAGES = acctilt_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [acctilt_pkg::ROOT_W-1:0]         in_den  [acctilt_pkg::LANES],
  input  acctilt_pkg::lane_meta_t                in_meta [acctilt_pkg::LANES],
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [acctilt_pkg::DEG_W-1:0]          out_deg [acctilt_pkg::LANES]
);

  localparam int S        = CORDIC_STAGES;
  localparam int LANES    = acctilt_pkg::LANES;
  localparam int XY_W     = acctilt_pkg::XY_W;
  localparam int Z_W      = acctilt_pkg::Z_W;
  localparam int ANG_FRAC = acctilt_pkg::ANG_FRAC;
  localparam int DEG_W    = acctilt_pkg::DEG_W;
  localparam int WHOLE_W  = Z_W - ANG_FRAC;

  logic                    v_r   [0:S];
  logic                    rdy   [0:S];
  logic signed [XY_W-1:0]  x_r   [LANES][0:S];
  logic signed [XY_W-1:0]  y_r   [LANES][0:S];
  logic signed [Z_W-1:0]   z_r   [LANES][0:S];
  logic                    neg_r [LANES][0:S];
  logic                    nz_r  [LANES][0:S];
  logic                    dz_r  [LANES][0:S];
  logic signed [XY_W-1:0]  x_nxt [LANES][1:S];
  logic signed [XY_W-1:0]  y_nxt [LANES][1:S];
  logic signed [Z_W-1:0]   z_nxt [LANES][1:S];

  logic                    vo_r;
  logic                    rdy_o;
  logic [DEG_W-1:0]        deg_r   [LANES];
  logic [DEG_W-1:0]        deg_nxt [LANES];

  assign rdy_o  = !vo_r || out_ready;
  assign rdy[S] = !v_r[S] || rdy_o;
  for (genvar k = 0; k < S; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = vo_r;
  assign out_deg   = deg_r;

  // vectoring micro-rotations, no rotation on a zero residual
  always_comb begin
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic                   ypos;
    logic                   yneg;
    for (int l = 0; l < LANES; l++) begin
      for (int k = 1; k <= S; k++) begin
        xs   = x_r[l][k-1] >>> (k - 1);
        ys   = y_r[l][k-1] >>> (k - 1);
        yneg = y_r[l][k-1][XY_W-1];
        ypos = !yneg && (y_r[l][k-1] != '0);
        if (ypos) begin
          x_nxt[l][k] = x_r[l][k-1] + ys;
          y_nxt[l][k] = y_r[l][k-1] - xs;
          z_nxt[l][k] = z_r[l][k-1] + Z_W'(acctilt_pkg::atan_entry(k - 1));
        end else if (yneg) begin
          x_nxt[l][k] = x_r[l][k-1] - ys;
          y_nxt[l][k] = y_r[l][k-1] + xs;
          z_nxt[l][k] = z_r[l][k-1] - Z_W'(acctilt_pkg::atan_entry(k - 1));
        end else begin
          x_nxt[l][k] = x_r[l][k-1];
          y_nxt[l][k] = y_r[l][k-1];
          z_nxt[l][k] = z_r[l][k-1];
        end
      end
    end
  end

  // whole degrees, clamp, sign
  always_comb begin
    logic [WHOLE_W-1:0] whole;
    logic [DEG_W-1:0]   mag;
    for (int l = 0; l < LANES; l++) begin
      if (z_r[l][S][Z_W-1]) begin
        whole = '0;
      end else begin
        whole = z_r[l][S][Z_W-1:ANG_FRAC];
      end
      if (whole > WHOLE_W'(acctilt_pkg::DEG_MAX)) begin
        whole = WHOLE_W'(acctilt_pkg::DEG_MAX);
      end
      if (nz_r[l][S]) begin
        mag = '0;
      end else if (dz_r[l][S]) begin
        mag = DEG_W'(acctilt_pkg::DEG_MAX);
      end else begin
        mag = whole[DEG_W-1:0];
      end
      deg_nxt[l] = neg_r[l][S] ? (DEG_W'(0) - mag) : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= S; k++) begin
        v_r[k] <= 1'b0;
      end
      vo_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k <= S; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (rdy_o) begin
        vo_r <= v_r[S];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (rdy[0] && in_valid) begin
        x_r[l][0]   <= XY_W'(in_den[l]) << acctilt_pkg::GUARD_BITS;
        y_r[l][0]   <= XY_W'(in_meta[l].ymag) << acctilt_pkg::GUARD_BITS;
        z_r[l][0]   <= '0;
        neg_r[l][0] <= in_meta[l].neg;
        nz_r[l][0]  <= (in_meta[l].ymag == '0);
        dz_r[l][0]  <= (in_den[l] == '0);
      end
      for (int k = 1; k <= S; k++) begin
        if (rdy[k] && v_r[k-1]) begin
          x_r[l][k]   <= x_nxt[l][k];
          y_r[l][k]   <= y_nxt[l][k];
          z_r[l][k]   <= z_nxt[l][k];
          neg_r[l][k] <= neg_r[l][k-1];
          nz_r[l][k]  <= nz_r[l][k-1];
          dz_r[l][k]  <= dz_r[l][k-1];
        end
      end
      if (rdy_o && v_r[S]) begin
        deg_r[l] <= deg_nxt[l];
      end
    end
  end

endmodule

// File: hw/rtl/accel_tilt_angles_unit.sv
// pipeline: 2 input stages, 33 square root stages, CORDIC_STAGES + 1 CORDIC stages
// and the output register
// throughput: one sample per cycle while out_tready is high; empty stages fill
// while the output is stalled
// reset: synchronous active-low rst_n clears all stage valid bits, no data is kept
module accel_tilt_angles_unit #(
  parameter int SAMPLE_WIDTH  = acctilt_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = acctilt_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // accel_x, accel_y, accel_z
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]       in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // tilt_x_deg, tilt_y_deg
  output logic [2*acctilt_pkg::DEG_W-1:0]           out_tdata
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int FRAC  = 32 - SAMPLE_WIDTH;
  localparam int LANES = acctilt_pkg::LANES;
  localparam int RAD_W = acctilt_pkg::RAD_W;
  localparam int NUM_W = acctilt_pkg::NUM_W;

  logic                   v1_r;
  logic                   v2_r;
  logic                   rdy1;
  logic                   rdy2;
  logic signed [SW-1:0]   ax_r;
  logic signed [SW-1:0]   ay_r;
  logic signed [SW-1:0]   az_r;
  logic [2*SW-1:0]        sqx_r;
  logic [2*SW-1:0]        sqy_r;
  logic [2*SW-1:0]        sqz_r;
  logic [NUM_W-1:0]       ymx_r;
  logic [NUM_W-1:0]       ymy_r;
  logic                   negx_r;
  logic                   negy_r;
  logic [SW-1:0]          absx;
  logic [SW-1:0]          absy;
  logic signed [2*SW-1:0] prx;
  logic signed [2*SW-1:0] pry;
  logic signed [2*SW-1:0] prz;

  logic                                  sq_ready;
  logic [RAD_W-1:0]                      sq_rad  [LANES];
  acctilt_pkg::lane_meta_t               sq_meta [LANES];
  logic                                  mid_valid;
  logic                                  mid_ready;
  logic [acctilt_pkg::ROOT_W-1:0]        mid_root [LANES];
  acctilt_pkg::lane_meta_t               mid_meta [LANES];
  logic [acctilt_pkg::DEG_W-1:0]         deg      [LANES];

  assign rdy2      = !v2_r || sq_ready;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign absx = ax_r[SW-1] ? SW'(-ax_r) : SW'(ax_r);
  assign absy = ay_r[SW-1] ? SW'(-ay_r) : SW'(ay_r);
  assign prx  = ax_r * ax_r;
  assign pry  = ay_r * ay_r;
  assign prz  = az_r * az_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      ax_r <= in_tdata[SW-1:0];
      ay_r <= in_tdata[2*SW-1:SW];
      az_r <= in_tdata[3*SW-1:2*SW];
    end
    if (rdy2 && v1_r) begin
      sqx_r  <= prx;
      sqy_r  <= pry;
      sqz_r  <= prz;
      ymx_r  <= NUM_W'(absx) << FRAC;
      ymy_r  <= NUM_W'(absy) << FRAC;
      negx_r <= ax_r[SW-1];
      negy_r <= ay_r[SW-1];
    end
  end

  // lane 0 is the x tilt, lane 1 the y tilt
  assign sq_rad[0]       = (RAD_W'(sqy_r) + RAD_W'(sqz_r)) << (2 * FRAC);
  assign sq_rad[1]       = (RAD_W'(sqx_r) + RAD_W'(sqz_r)) << (2 * FRAC);
  assign sq_meta[0].neg  = negx_r;
  assign sq_meta[0].ymag = ymx_r;
  assign sq_meta[1].neg  = negy_r;
  assign sq_meta[1].ymag = ymy_r;

  acctilt_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_ready  (sq_ready),
    .in_rad    (sq_rad),
    .in_meta   (sq_meta),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_root  (mid_root),
    .out_meta  (mid_meta)
  );

  acctilt_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_den    (mid_root),
    .in_meta   (mid_meta),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_deg   (deg)
  );

  assign out_tdata = {deg[1], deg[0]};

endmodule
